@@ src/mrpd_pkg.sv @@
// Shared types and constants for the masked record pattern dedup unit.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package mrpd_pkg;

  // Sizing of the pattern table and of one record
  localparam int MaxRecords = 256;
  localparam int MaxItems   = 16;
  localparam int ValueBits  = 4;
  localparam int NibbleW    = 4;
  localparam int MaskW      = 16;
  localparam int ValuesW    = 64;
  localparam int ItemsW     = 5;
  localparam int IdxW       = $clog2(MaxRecords);
  localparam int CntW       = IdxW + 1;
  localparam int RecW       = 8;
  localparam int CountW     = 9;

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic [0:0] RegItemsInUse = 1'b0;
  localparam logic [ItemsW-1:0] ItemsReset = ItemsW'(MaxItems);

  typedef struct packed {
    logic               start_group;
    logic [MaskW-1:0]   missing_mask;
    logic [ValuesW-1:0] item_values;
  } in_item_t;

  typedef struct packed {
    logic [RecW-1:0]   record_index;
    logic [RecW-1:0]   pattern_index;
    logic              is_new;
    logic [CountW-1:0] pattern_count;
    logic              overflow;
  } out_item_t;

  // One stored pattern as it travels around the ring
  typedef struct packed {
    logic [MaskW-1:0]   mask;
    logic [ValuesW-1:0] values;
    logic [IdxW-1:0]    first;
    logic [CntW-1:0]    count;
  } entry_t;

endpackage

@@ src/mrpd_cell.sv @@
// One cell of the pattern ring: holds a stored pattern and passes it on.
// Depends on mrpd_pkg.
`timescale 1ns / 1ps

module mrpd_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  mrpd_pkg::entry_t entry_i,
  output mrpd_pkg::entry_t entry_o
);

  mrpd_pkg::entry_t entry_q;

  // Take the neighbor's pattern on every rotation step
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ src/mrpd_match.sv @@
// Pattern compare at the ring head: masks equal and observed values equal.
// Depends on mrpd_pkg.
`timescale 1ns / 1ps

module mrpd_match (
  input  logic [mrpd_pkg::MaskW-1:0]   stored_mask_i,
  input  logic [mrpd_pkg::ValuesW-1:0] stored_values_i,
  input  logic [mrpd_pkg::MaskW-1:0]   probe_mask_i,
  input  logic [mrpd_pkg::ValuesW-1:0] probe_values_i,
  input  logic [mrpd_pkg::ItemsW-1:0]  items_i,
  output logic                         match_o
);

  logic [mrpd_pkg::ItemsW-1:0] used;
  logic                        diff;

  // Items in use saturate at the item count
  assign used = (items_i > mrpd_pkg::ItemsW'(mrpd_pkg::MaxItems)) ?
                mrpd_pkg::ItemsW'(mrpd_pkg::MaxItems) : items_i;

  // Per-item mismatch, only for items in use
  always_comb begin
    diff = 1'b0;
    for (int k = 0; k < mrpd_pkg::MaxItems; k++) begin
      if (mrpd_pkg::ItemsW'(k) < used) begin
        if (stored_mask_i[k] != probe_mask_i[k]) begin
          diff = 1'b1;
        end
        if (!probe_mask_i[k] &&
            (stored_values_i[k*mrpd_pkg::NibbleW +: mrpd_pkg::ValueBits] !=
             probe_values_i[k*mrpd_pkg::NibbleW +: mrpd_pkg::ValueBits])) begin
          diff = 1'b1;
        end
      end
    end
  end

  assign match_o = !diff;

endmodule

@@ src/masked_record_pattern_dedup_unit.sv @@
// Top level of the masked record pattern dedup unit: control, ring, config.
// Depends on mrpd_pkg, mrpd_cell and mrpd_match.
`timescale 1ns / 1ps
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  in      | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//  config  | input     | APB psel/penable/pready | items_in_use at addr 0
//
// Stored patterns circulate in a ring of MaxRecords cells, one step a cycle
// while a record is scanned. A record takes one full turn, then the hold
// state loads the output register and the unit returns to idle before it
// accepts the next item. A record that finds its group full skips the turn
// and goes to hold. Reset empties the table counters; no clearing pass is
// needed. A stalled output holds its item; the next result waits in the unit.

module masked_record_pattern_dedup_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mrpd_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mrpd_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrpd_pkg::PaddrW-1:0]   paddr,
  input  logic [mrpd_pkg::PdataW-1:0]   pwdata,
  output logic [mrpd_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  localparam int N    = mrpd_pkg::MaxRecords;
  localparam int IdxW = mrpd_pkg::IdxW;
  localparam int CntW = mrpd_pkg::CntW;

  logic [1:0]                     state_q, state_d;
  logic [IdxW-1:0]                step_q, step_d;
  logic                           found_q, found_d;
  logic [CntW-1:0]                records_q, records_d;
  logic [CntW-1:0]                distinct_q, distinct_d;
  logic [mrpd_pkg::ItemsW-1:0]    items_q;
  logic [mrpd_pkg::MaskW-1:0]     probe_mask_q, probe_mask_d;
  logic [mrpd_pkg::ValuesW-1:0]   probe_values_q, probe_values_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  mrpd_pkg::out_item_t            res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  mrpd_pkg::out_item_t            out_item_q, out_item_d;

  mrpd_pkg::entry_t               ring [N];
  mrpd_pkg::entry_t               tail_d;
  mrpd_pkg::entry_t               head;
  logic                           shift;
  logic                           match;
  logic                           in_acc;
  logic                           out_free;
  logic                           live;
  logic                           hit;
  logic                           new_slot;
  logic [CntW-1:0]                start_records;
  logic [CntW-1:0]                start_distinct;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == mrpd_pkg::RegItemsInUse) ?
                  mrpd_pkg::PdataW'(items_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q <= mrpd_pkg::ItemsReset;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == mrpd_pkg::RegItemsInUse)) begin
      items_q <= pwdata[mrpd_pkg::ItemsW-1:0];
    end
  end

  // Pattern ring: cell i takes cell i+1, the last cell takes the tail data
  assign head  = ring[0];
  assign shift = (state_q == StScan);

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == N - 1) begin : g_tail
      mrpd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .entry_i (tail_d),
        .entry_o (ring[i])
      );
    end else begin : g_body
      mrpd_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .entry_i (ring[i+1]),
        .entry_o (ring[i])
      );
    end
  end

  // Compare at the ring head
  mrpd_match u_match (
    .stored_mask_i   (head.mask),
    .stored_values_i (head.values),
    .probe_mask_i    (probe_mask_q),
    .probe_values_i  (probe_values_q),
    .items_i         (items_q),
    .match_o         (match)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign start_records  = in_item_i.start_group ? '0 : records_q;
  assign start_distinct = in_item_i.start_group ? '0 : distinct_q;

  // Head slot is a stored pattern, the first match, or the free slot
  assign live     = ({1'b0, step_q} < distinct_q);
  assign hit      = live && !found_q && match;
  assign new_slot = ({1'b0, step_q} == distinct_q) && !found_q;

  always_comb begin
    tail_d = head;
    if (hit) begin
      tail_d.count = head.count + CntW'(1);
    end else if (new_slot) begin
      tail_d.mask   = probe_mask_q;
      tail_d.values = probe_values_q;
      tail_d.first  = idx_q;
      tail_d.count  = CntW'(1);
    end
  end

  // Sequencer
  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    found_d        = found_q;
    records_d      = records_q;
    distinct_d     = distinct_q;
    probe_mask_d   = probe_mask_q;
    probe_values_d = probe_values_q;
    idx_d          = idx_q;
    res_d          = res_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_item_d     = out_item_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          records_d  = start_records;
          distinct_d = start_distinct;
          if (start_records >= CntW'(N)) begin
            res_d          = '0;
            res_d.overflow = 1'b1;
            state_d        = StHold;
          end else begin
            probe_mask_d   = in_item_i.missing_mask;
            probe_values_d = in_item_i.item_values;
            idx_d          = start_records[IdxW-1:0];
            step_d         = '0;
            found_d        = 1'b0;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        if (hit) begin
          found_d             = 1'b1;
          res_d.record_index  = mrpd_pkg::RecW'(idx_q);
          res_d.pattern_index = mrpd_pkg::RecW'(head.first);
          res_d.is_new        = 1'b0;
          res_d.pattern_count = mrpd_pkg::CountW'(head.count + CntW'(1));
          res_d.overflow      = 1'b0;
        end else if (new_slot) begin
          found_d             = 1'b1;
          res_d.record_index  = mrpd_pkg::RecW'(idx_q);
          res_d.pattern_index = mrpd_pkg::RecW'(idx_q);
          res_d.is_new        = 1'b1;
          res_d.pattern_count = mrpd_pkg::CountW'(1);
          res_d.overflow      = 1'b0;
        end
        step_d = step_q + IdxW'(1);
        if (step_q == IdxW'(N - 1)) begin
          records_d  = records_q + CntW'(1);
          distinct_d = distinct_q + CntW'(res_d.is_new);
          state_d    = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      found_q     <= 1'b0;
      records_q   <= '0;
      distinct_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      records_q   <= records_d;
      distinct_q  <= distinct_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    probe_mask_q   <= probe_mask_d;
    probe_values_q <= probe_values_d;
    idx_q          <= idx_d;
    res_q          <= res_d;
    out_item_q     <= out_item_d;
  end

endmodule

@@ src/mrpd_checker.sv @@
// Port-level checks for the masked record pattern dedup unit, plus bind.
// Depends on mrpd_pkg and masked_record_pattern_dedup_unit.
`timescale 1ns / 1ps

module mrpd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mrpd_pkg::out_item_t out_item_o
);

  // One record at a time: after an accept the input side is stalled
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a record is in progress");

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output item changed or dropped");

  // Overflow result carries all-zero fields
  a_overflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.overflow) |->
    (out_item_o.record_index == '0 && out_item_o.pattern_index == '0 &&
     !out_item_o.is_new && out_item_o.pattern_count == '0))
    else $error("overflow item with nonzero fields");

  // A new pattern points at itself and has count one
  a_new_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.is_new) |->
    (out_item_o.pattern_index == out_item_o.record_index &&
     out_item_o.pattern_count == mrpd_pkg::CountW'(1) && !out_item_o.overflow))
    else $error("new pattern item inconsistent");

  // A stored record always has a nonzero count no newer than itself
  a_old_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.overflow) |->
    (out_item_o.pattern_count != '0 &&
     out_item_o.pattern_index <= out_item_o.record_index))
    else $error("counted item with bad count or pattern index");

endmodule

bind masked_record_pattern_dedup_unit mrpd_checker u_mrpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
